// ===== hw/rtl/bfsc_pkg.sv =====
package bfsc_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;

    localparam int DEBOUNCE_WIDTH   = 10;
    localparam int LONG_PRESS_WIDTH = 16;
    localparam int BLINK_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH   = 16;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int LEVEL_WIDTH      = 2;

    typedef logic [LEVEL_WIDTH-1:0] level_t;

    localparam level_t LEVEL_OFF  = 2'd0;
    localparam level_t LEVEL_ONE  = 2'd1;
    localparam level_t LEVEL_TWO  = 2'd2;
    localparam level_t LEVEL_MAX  = 2'd3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_BLINK_HALF = 2'd2
    } cfg_index_t;

    localparam logic [DEBOUNCE_WIDTH-1:0]   DEBOUNCE_RESET   = 10'd100;
    localparam logic [LONG_PRESS_WIDTH-1:0] LONG_PRESS_RESET = 16'd2000;
    localparam logic [BLINK_WIDTH-1:0]      BLINK_HALF_RESET = 16'd300;

    // speed sequence 1 -> 2 -> 3 -> 1
    function automatic level_t next_speed(input level_t lvl);
        level_t nxt;
        nxt = (lvl == LEVEL_MAX) ? LEVEL_ONE : level_t'(lvl + 2'd1);
        return nxt;
    endfunction

endpackage

// ===== hw/rtl/button_fan_speed_controller.sv =====
// Three-speed fan controller driven by one push button and an external cycle request. Each
// input transfer is one millisecond tick carrying the active-low button level and the
// request; each tick gives exactly one output transfer with the fan level, the one-hot
// drive pins and the indicator LED as they stand after that tick. A short press toggles
// power (restoring the saved speed), a long press or a request steps the speed 1-2-3-1,
// and the LED blinks once per level after every change. The block takes one tick per
// clock: the whole update is a single combinational pass from the state registers into
// the state and result registers, so a result appears in the cycle after its tick is taken,
// and a new tick is taken whenever the result register is empty or being emptied.
// Configuration writes are taken at once and should only be made while no tick is in
// flight.
module button_fan_speed_controller #(
    parameter int TIMER_WIDTH = bfsc_pkg::TIMER_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 button_level,
    input  logic                                 cycle_request,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [bfsc_pkg::LEVEL_WIDTH-1:0]     speed_level,
    output logic                                 drive_low,
    output logic                                 drive_mid,
    output logic                                 drive_high,
    output logic                                 led_on,
    input  logic                                 cfg_write_en,
    input  logic [bfsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bfsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > bfsc_pkg::LONG_PRESS_WIDTH) ?
                               TIMER_WIDTH : bfsc_pkg::LONG_PRESS_WIDTH;
    localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

    // configuration
    logic [bfsc_pkg::DEBOUNCE_WIDTH-1:0]   debounce_reg;
    logic [bfsc_pkg::LONG_PRESS_WIDTH-1:0] long_press_reg;
    logic [bfsc_pkg::BLINK_WIDTH-1:0]      blink_half_reg;

    // controller state
    logic                     prev_button_reg, prev_button_next;
    logic                     press_pending_reg, press_pending_next;
    logic [TIMER_WIDTH-1:0]   hold_count_reg, hold_count_next;
    bfsc_pkg::level_t         level_now_reg, level_now_next;
    bfsc_pkg::level_t         level_saved_reg, level_saved_next;
    logic [1:0]               blinks_left_reg, blinks_left_next;
    logic                     blink_phase_off_reg, blink_phase_off_next;
    logic [TIMER_WIDTH-1:0]   blink_count_reg, blink_count_next;
    logic                     led_state_reg, led_state_next;

    // result register
    logic                     out_valid_reg;
    bfsc_pkg::level_t         speed_level_reg;
    logic                     drive_low_reg;
    logic                     drive_mid_reg;
    logic                     drive_high_reg;
    logic                     led_on_reg;

    logic                     in_accept;
    logic                     edge_seen;
    logic                     level_changed;

    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
        logic [TIMER_WIDTH-1:0] r;
        r = (v == TIMER_MAX) ? v : v + 1'b1;
        return r;
    endfunction

    // a saturated counter has reached any limit
    function automatic logic reached(input logic [TIMER_WIDTH-1:0] count,
                                     input logic [CMP_WIDTH-1:0]   limit);
        logic r;
        r = (CMP_WIDTH'(count) >= limit) || (count == TIMER_MAX);
        return r;
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign edge_seen = (button_level != prev_button_reg);

    always_comb
    begin
        prev_button_next     = button_level;
        press_pending_next   = press_pending_reg;
        hold_count_next      = hold_count_reg;
        level_now_next       = level_now_reg;
        level_saved_next     = level_saved_reg;
        blinks_left_next     = blinks_left_reg;
        blink_phase_off_next = blink_phase_off_reg;
        blink_count_next     = blink_count_reg;
        led_state_next       = led_state_reg;
        level_changed        = 1'b0;

        // blink sequencer runs alongside the button
        if (blinks_left_reg != 2'd0)
        begin
            blink_count_next = sat_inc(blink_count_reg);
            if (reached(blink_count_next, CMP_WIDTH'(blink_half_reg)))
            begin
                blink_count_next = '0;
                if (blink_phase_off_reg)
                begin
                    blink_phase_off_next = 1'b0;
                    led_state_next       = 1'b1;
                end
                else
                begin
                    blinks_left_next = blinks_left_reg - 2'd1;
                    if (blinks_left_next != 2'd0)
                    begin
                        blink_phase_off_next = 1'b1;
                        led_state_next       = 1'b0;
                    end
                end
            end
        end

        // press timing; an edge wins over the long-press timeout
        if (press_pending_reg)
        begin
            hold_count_next = sat_inc(hold_count_reg);
            if (edge_seen)
            begin
                press_pending_next = 1'b0;
                if (hold_count_next >= TIMER_WIDTH'(debounce_reg))
                begin
                    level_changed  = 1'b1;
                    level_now_next = (level_now_reg == bfsc_pkg::LEVEL_OFF) ?
                                     level_saved_reg : bfsc_pkg::LEVEL_OFF;
                end
            end
            else if (reached(hold_count_next, CMP_WIDTH'(long_press_reg)))
            begin
                press_pending_next = 1'b0;
                if (level_now_reg != bfsc_pkg::LEVEL_OFF)
                begin
                    level_changed    = 1'b1;
                    level_now_next   = bfsc_pkg::next_speed(level_now_reg);
                    level_saved_next = level_now_next;
                end
            end
        end
        else if (edge_seen && !button_level)
        begin
            press_pending_next = 1'b1;
            hold_count_next    = '0;
        end

        // cycle request acts after the button action
        if (cycle_request && level_now_next != bfsc_pkg::LEVEL_OFF)
        begin
            level_changed    = 1'b1;
            level_now_next   = bfsc_pkg::next_speed(level_now_next);
            level_saved_next = level_now_next;
        end

        // every level change restarts the blink with the led off
        if (level_changed)
        begin
            blinks_left_next     = level_now_next;
            blink_phase_off_next = (level_now_next != bfsc_pkg::LEVEL_OFF);
            blink_count_next     = '0;
            led_state_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bfsc_pkg::DEBOUNCE_RESET;
            long_press_reg <= bfsc_pkg::LONG_PRESS_RESET;
            blink_half_reg <= bfsc_pkg::BLINK_HALF_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                bfsc_pkg::CFG_DEBOUNCE:
                    debounce_reg <= cfg_data[bfsc_pkg::DEBOUNCE_WIDTH-1:0];
                bfsc_pkg::CFG_LONG_PRESS:
                    long_press_reg <= cfg_data[bfsc_pkg::LONG_PRESS_WIDTH-1:0];
                bfsc_pkg::CFG_BLINK_HALF:
                    blink_half_reg <= cfg_data[bfsc_pkg::BLINK_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_button_reg     <= 1'b1;
            press_pending_reg   <= 1'b0;
            hold_count_reg      <= '0;
            level_now_reg       <= bfsc_pkg::LEVEL_OFF;
            level_saved_reg     <= bfsc_pkg::LEVEL_ONE;
            blinks_left_reg     <= 2'd0;
            blink_phase_off_reg <= 1'b0;
            blink_count_reg     <= '0;
            led_state_reg       <= 1'b0;
        end
        else if (in_accept)
        begin
            prev_button_reg     <= prev_button_next;
            press_pending_reg   <= press_pending_next;
            hold_count_reg      <= hold_count_next;
            level_now_reg       <= level_now_next;
            level_saved_reg     <= level_saved_next;
            blinks_left_reg     <= blinks_left_next;
            blink_phase_off_reg <= blink_phase_off_next;
            blink_count_reg     <= blink_count_next;
            led_state_reg       <= led_state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            speed_level_reg <= level_now_next;
            drive_low_reg   <= (level_now_next == bfsc_pkg::LEVEL_ONE);
            drive_mid_reg   <= (level_now_next == bfsc_pkg::LEVEL_TWO);
            drive_high_reg  <= (level_now_next == bfsc_pkg::LEVEL_MAX);
            led_on_reg      <= led_state_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign speed_level = speed_level_reg;
    assign drive_low   = drive_low_reg;
    assign drive_mid   = drive_mid_reg;
    assign drive_high  = drive_high_reg;
    assign led_on      = led_on_reg;

    // a waiting result blocks the next tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("tick taken while result stalled");

    // led stays dark while the fan is off
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && speed_level == bfsc_pkg::LEVEL_OFF |-> !led_on)
        else $error("led lit at level off");

    // drive pins follow the reported level
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({drive_high, drive_mid, drive_low}) &&
                      (drive_low || drive_mid || drive_high) ==
                      (speed_level != bfsc_pkg::LEVEL_OFF))
        else $error("drive pins disagree with level");

    // the saved speed is never off
    assert property (@(posedge clk) disable iff (!rst_n)
        level_saved_reg != bfsc_pkg::LEVEL_OFF)
        else $error("saved level is off");

    // no off half is pending once the blink sequence has ended
    assert property (@(posedge clk) disable iff (!rst_n)
        blinks_left_reg == 2'd0 |-> !blink_phase_off_reg)
        else $error("blink phase set with no blinks left");

endmodule

// ===== sim/button_fan_speed_controller_tb.sv =====
module button_fan_speed_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMER_BITS   = bfsc_pkg::TIMER_WIDTH_DEFAULT;
    localparam int RANDOM_TICKS = 900;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef logic [TIMER_BITS-1:0] tick_count_t;
    typedef logic [bfsc_pkg::CFG_DATA_WIDTH-1:0] cfg_word_t;
    typedef logic [bfsc_pkg::DEBOUNCE_WIDTH-1:0] debounce_t;

    typedef struct packed {
        bfsc_pkg::level_t level;
        logic   drv_lo;
        logic   drv_mid;
        logic   drv_hi;
        logic   led;
    } fan_outputs_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       button_level;
    logic                       cycle_request;
    logic                       out_valid;
    logic                       out_ready;
    bfsc_pkg::level_t           speed_level;
    logic                       drive_low;
    logic                       drive_mid;
    logic                       drive_high;
    logic                       led_on;
    logic                       cfg_write_en;
    bfsc_pkg::cfg_index_t       cfg_index;
    cfg_word_t                  cfg_data;

    // predictor copy of the controller
    debounce_t                  debounce_lim;
    tick_count_t                hold_lim;
    tick_count_t                blink_lim;
    logic                       last_button;
    logic                       press_held;
    tick_count_t                hold_ticks;
    bfsc_pkg::level_t           speed;
    bfsc_pkg::level_t           saved_speed;
    logic [1:0]                 blinks_to_go;
    logic                       blink_dark;
    tick_count_t                blink_timer;
    logic                       led;

    fan_outputs_t pending_outputs[$];
    int           mismatches  = 0;
    int           ticks_sent  = 0;
    int           cycle_count = 0;
    bit           tx_idle_on  = 1'b1;
    bit           rx_idle_on  = 1'b1;
    int           rx_hold_off = 0;

    button_fan_speed_controller dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, pending_outputs.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void reset_fan_model();
        debounce_lim = bfsc_pkg::DEBOUNCE_RESET;
        hold_lim     = bfsc_pkg::LONG_PRESS_RESET;
        blink_lim    = bfsc_pkg::BLINK_HALF_RESET;
        last_button  = 1'b1;
        press_held   = 1'b0;
        hold_ticks   = '0;
        speed        = bfsc_pkg::LEVEL_OFF;
        saved_speed  = bfsc_pkg::LEVEL_ONE;
        blinks_to_go = '0;
        blink_dark   = 1'b0;
        blink_timer  = '0;
        led          = 1'b0;
    endfunction

    function automatic tick_count_t sat_incr(tick_count_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // a saturated timer counts as having reached any limit
    function automatic bit timer_done(tick_count_t cnt, tick_count_t lim);
        return (cnt >= lim) || (cnt == '1);
    endfunction

    function automatic void set_speed(bfsc_pkg::level_t lvl);
        speed        = lvl;
        blinks_to_go = lvl;
        blink_dark   = (lvl != bfsc_pkg::LEVEL_OFF);
        blink_timer  = '0;
        led          = 1'b0;
    endfunction

    function automatic void step_speed();
        bfsc_pkg::level_t nxt;
        if (speed == bfsc_pkg::LEVEL_OFF)
            return;
        nxt = (speed == bfsc_pkg::LEVEL_MAX) ? bfsc_pkg::LEVEL_ONE :
                                               bfsc_pkg::level_t'(speed + 1'b1);
        saved_speed = nxt;
        set_speed(nxt);
    endfunction

    function automatic void predict_tick(logic btn, logic req);
        logic         btn_changed;
        fan_outputs_t res;
        btn_changed = (btn != last_button);
        if (blinks_to_go != 0) begin
            blink_timer = sat_incr(blink_timer);
            if (timer_done(blink_timer, blink_lim)) begin
                blink_timer = '0;
                if (blink_dark) begin
                    blink_dark = 1'b0;
                    led        = 1'b1;
                end
                else begin
                    blinks_to_go = blinks_to_go - 1'b1;
                    if (blinks_to_go != 0) begin
                        blink_dark = 1'b1;
                        led        = 1'b0;
                    end
                end
            end
        end
        if (press_held) begin
            hold_ticks = sat_incr(hold_ticks);
            // a release wins over the long-press timeout on the same tick
            if (btn_changed) begin
                press_held = 1'b0;
                if (hold_ticks >= tick_count_t'(debounce_lim))
                    set_speed((speed == bfsc_pkg::LEVEL_OFF) ? saved_speed :
                                                               bfsc_pkg::LEVEL_OFF);
            end
            else if (timer_done(hold_ticks, hold_lim)) begin
                press_held = 1'b0;
                step_speed();
            end
        end
        else if (btn_changed && !btn) begin
            press_held = 1'b1;
            hold_ticks = '0;
        end
        last_button = btn;
        if (req)
            step_speed();
        res.level   = speed;
        res.drv_lo  = (speed == bfsc_pkg::LEVEL_ONE);
        res.drv_mid = (speed == bfsc_pkg::LEVEL_TWO);
        res.drv_hi  = (speed == bfsc_pkg::LEVEL_MAX);
        res.led     = led;
        pending_outputs.push_back(res);
    endfunction

    function automatic void check_field(string name, logic [1:0] want, logic [1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin
        fan_outputs_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: output transfer with nothing expected, level %0d",
                         $time, speed_level);
                mismatches++;
            end
            else begin
                want = pending_outputs.pop_front();
                check_field("speed_level", want.level, speed_level);
                check_field("drive_low", 2'(want.drv_lo), 2'(drive_low));
                check_field("drive_mid", 2'(want.drv_mid), 2'(drive_mid));
                check_field("drive_high", 2'(want.drv_hi), 2'(drive_high));
                check_field("led_on", 2'(want.led), 2'(led_on));
            end
        end
    end

    // output side: random stall per transfer, or a long hold-off on request
    initial begin
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (rx_hold_off != 0) begin
                gap         = rx_hold_off;
                rx_hold_off = 0;
            end
            else
                gap = rx_idle_on ? int'($urandom_range(0, 8)) : 0;
            if (gap != 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    task automatic send_tick(input logic btn, input logic req);
        int gap;
        gap = tx_idle_on ? int'($urandom_range(0, 8)) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        button_level  <= btn;
        cycle_request <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predict_tick(btn, req);
        ticks_sent++;
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input int dbnc, input int hold, input int blink);
        cfg_write_en <= 1'b1;
        cfg_index    <= bfsc_pkg::CFG_DEBOUNCE;
        cfg_data     <= cfg_word_t'(dbnc);
        @(posedge clk);
        cfg_index    <= bfsc_pkg::CFG_LONG_PRESS;
        cfg_data     <= cfg_word_t'(hold);
        @(posedge clk);
        cfg_index    <= bfsc_pkg::CFG_BLINK_HALF;
        cfg_data     <= cfg_word_t'(blink);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        debounce_lim = debounce_t'(dbnc);
        hold_lim     = tick_count_t'(cfg_word_t'(hold));
        blink_lim    = tick_count_t'(cfg_word_t'(blink));
    endtask

    // reset timings: press one tick short of debounce, then exactly on it
    task automatic test_reset_defaults();
        send_tick(1'b0, 1'b0);
        repeat (98) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (99) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        repeat (310) send_tick(1'b1, 1'b0);
        drain_outputs();
    endtask

    task automatic test_directed();
        apply_settings(2, 4, 1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);                          // short press powers off
        send_tick(1'b1, 1'b1);                          // request while off is ignored
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);                          // bounce
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);                          // short press powers on
        send_tick(1'b1, 1'b1);
        repeat (5) send_tick(1'b0, 1'b0);               // long press wraps from top speed
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);                          // request during a press
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);                          // release on the timeout tick
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);                          // power on and step together
        repeat (3) send_tick(1'b1, 1'b0);
        drain_outputs();
    endtask

    task automatic test_zero_settings();
        apply_settings(0, 0, 0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        repeat (6) send_tick(1'b1, 1'b0);
        drain_outputs();
        apply_settings(0, 1, 0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (8) send_tick(1'b1, 1'b0);
        drain_outputs();
    endtask

    // widest long-press and blink settings with a long debounce, run back to back without idling
    task automatic test_extreme_timers();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_settings(1000, 16'hFFFF, 16'hFFFF);
        send_tick(1'b0, 1'b0);
        repeat (20) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);                          // far below debounce, dropped
        send_tick(1'b1, 1'b1);
        repeat (20) send_tick(1'b1, 1'b0);
        drain_outputs();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    task automatic test_random_gestures();
        int start;
        int phase;
        int gesture;
        int len;
        start = ticks_sent;
        phase = 0;
        while (ticks_sent - start < RANDOM_TICKS) begin
            drain_outputs();
            case ($urandom_range(0, 7))
                0: apply_settings(1, 2, 1);
                1: apply_settings(0, $urandom_range(0, 1), 0);
                2: apply_settings($urandom_range(0, 1023), $urandom_range(2, 30),
                                  $urandom_range(1, 8));
                default: apply_settings($urandom_range(1, 6), $urandom_range(2, 24),
                                        $urandom_range(1, 5));
            endcase
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 0)
                rx_hold_off = 60;
            for (gesture = 0; gesture < 12; gesture++) begin
                if (phase == 1 && gesture == 6)
                    drain_outputs();
                if ($urandom_range(0, 6) == 0) begin
                    len = $urandom_range(1, 12);
                    repeat (len) send_tick(1'($urandom_range(0, 1)),
                                           1'($urandom_range(0, 1)));
                end
                else begin
                    len = $urandom_range(0, 4);
                    repeat (len) send_tick(1'b1, $urandom_range(0, 11) == 0);
                    len = $urandom_range(1, int'(hold_lim) + 3);
                    repeat (len) send_tick(1'b0, $urandom_range(0, 11) == 0);
                end
            end
            phase++;
        end
        drain_outputs();
    endtask

    initial begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        button_level  = 1'b1;
        cycle_request = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = bfsc_pkg::CFG_DEBOUNCE;
        cfg_data      = '0;
        reset_fan_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_zero_settings();
        test_extreme_timers();
        test_random_gestures();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
